>>> sv/mvrc_pkg.sv
// ---------------------------------------------------------------------------
// mvrc_pkg
// Shared types and constants of the multi-version row compactor.
// ---------------------------------------------------------------------------
package mvrc_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned VER_W = 63;
  localparam int unsigned SEQ_W = 63;
  localparam int unsigned PAY_W = 32;
  localparam int unsigned OSEQ_W = 64;

  // Sequence number carried by the shadow row: negated largest signed 64-bit value.
  localparam logic signed [OSEQ_W-1:0] SHADOW_SEQ = 64'sh8000000000000001;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_KEY     = 3'd1,
    STAT_VERSION = 3'd2,
    STAT_EMPTY   = 3'd3,
    STAT_FULL    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EMIT
  } state_e;

  // One queued version of the current key.
  typedef struct packed {
    logic [VER_W-1:0] version;
    logic [PAY_W-1:0] payload;
  } entry_t;

  // One result item.
  typedef struct packed {
    logic                     row_valid;
    logic [KEY_W-1:0]         key;
    logic [VER_W-1:0]         version;
    logic signed [OSEQ_W-1:0] seq;
    logic [PAY_W-1:0]         payload;
    logic                     first_flag;
    logic                     last_flag;
    logic                     shadow_flag;
    logic                     compacted_flag;
    status_e                  status;
    logic                     last_result;
  } result_t;

  // Result that carries only a status.
  function automatic result_t status_result(status_e st);
    result_t r;
    r             = '0;
    r.status      = st;
    r.last_result = 1'b1;
    return r;
  endfunction

endpackage

>>> sv/mvrc_queue_mem.sv
// ---------------------------------------------------------------------------
// mvrc_queue_mem
// Version queue storage: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module mvrc_queue_mem import mvrc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/mvrc_out_reg.sv
// ---------------------------------------------------------------------------
// mvrc_out_reg
// Output register of the result channel; frees as soon as the result is taken.
// ---------------------------------------------------------------------------
module mvrc_out_reg import mvrc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t data_i,
  output logic    free_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  logic    valid_q, valid_d;
  result_t data_q, data_d;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load_i && free_o) begin
      valid_d = 1'b1;
      data_d  = data_i;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> sv/multi_version_row_compactor.sv
// ---------------------------------------------------------------------------
// multi_version_row_compactor
// Compacts sorted multi-version rows into per-key groups.
// ---------------------------------------------------------------------------
// A push or an empty finish writes its status result to the output register on
// the cycle of the request, and the next request is taken on the following
// cycle provided the output register is free. A group flush passes through
// S_READ and then S_EMIT for each emitted row (a single row, or the shadow row
// plus one row per queued version), as set by the version queue memory's single
// read port and its registered read; no request is taken during a flush. A push
// whose key is larger than the queued key flushes the group and then starts the
// new group from it. The queue memory needs no clearing after reset.
module multi_version_row_compactor import mvrc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     operation_i,
  input  logic [KEY_W-1:0]         row_key_i,
  input  logic [VER_W-1:0]         trans_version_i,
  input  logic [SEQ_W-1:0]         seq_number_i,
  input  logic [PAY_W-1:0]         payload_handle_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     row_valid_o,
  output logic [KEY_W-1:0]         out_key_o,
  output logic [VER_W-1:0]         out_version_o,
  output logic signed [OSEQ_W-1:0] out_seq_o,
  output logic [PAY_W-1:0]         out_payload_o,
  output logic                     first_flag_o,
  output logic                     last_flag_o,
  output logic                     shadow_flag_o,
  output logic                     compacted_flag_o,
  output logic [2:0]               status_o,
  output logic                     last_result_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

  state_e           state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    pos_q, pos_d;
  logic             pend_q, pend_d;
  logic [KEY_W-1:0] gkey_q, gkey_d;
  logic [SEQ_W-1:0] tail_seq_q, tail_seq_d;
  logic [VER_W-1:0] tail_ver_q, tail_ver_d;
  logic [KEY_W-1:0] pkey_q, pkey_d;
  logic [SEQ_W-1:0] pseq_q, pseq_d;
  entry_t           pent_q, pent_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  entry_t        mem_rdata;

  logic    out_load;
  logic    out_free;
  result_t out_din;
  result_t out_dout;

  logic    accept;
  logic    multi;
  logic    last_pos;
  entry_t  in_entry;

  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign multi      = (count_q > CW'(1));
  assign last_pos   = multi ? (pos_q == count_q) : 1'b1;
  assign in_entry   = '{version: trans_version_i, payload: payload_handle_i};

  mvrc_queue_mem #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  mvrc_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .data_i  (out_din),
    .free_o  (out_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_dout)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    pos_d      = pos_q;
    pend_d     = pend_q;
    gkey_d     = gkey_q;
    tail_seq_d = tail_seq_q;
    tail_ver_d = tail_ver_q;
    pkey_d     = pkey_q;
    pseq_d     = pseq_q;
    pent_d     = pent_q;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = in_entry;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    out_load   = 1'b0;
    out_din    = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (operation_i) begin
            if (count_q == '0) begin
              out_load = 1'b1;
              out_din  = status_result(STAT_EMPTY);
            end else begin
              pos_d   = '0;
              pend_d  = 1'b0;
              state_d = S_READ;
            end
          end else if (count_q == '0) begin
            mem_we     = 1'b1;
            gkey_d     = row_key_i;
            tail_seq_d = seq_number_i;
            tail_ver_d = trans_version_i;
            count_d    = CW'(1);
            out_load   = 1'b1;
            out_din    = status_result(STAT_OK);
          end else if (row_key_i < gkey_q) begin
            out_load = 1'b1;
            out_din  = status_result(STAT_KEY);
          end else if (row_key_i == gkey_q) begin
            out_load = 1'b1;
            if (tail_ver_q > trans_version_i) begin
              out_din = status_result(STAT_VERSION);
            end else if (tail_ver_q == trans_version_i) begin
              // repeated version keeps the first entry
              out_din = status_result((tail_seq_q >= seq_number_i) ? STAT_VERSION
                                                                    : STAT_OK);
            end else if (count_q == FULL_COUNT) begin
              out_din = status_result(STAT_FULL);
            end else begin
              mem_we     = 1'b1;
              mem_waddr  = count_q[AW-1:0];
              count_d    = count_q + CW'(1);
              tail_seq_d = seq_number_i;
              tail_ver_d = trans_version_i;
              out_din    = status_result(STAT_OK);
            end
          end else begin
            // larger key: flush, then start the new group from this row
            pkey_d  = row_key_i;
            pseq_d  = seq_number_i;
            pent_d  = in_entry;
            pend_d  = 1'b1;
            pos_d   = '0;
            state_d = S_READ;
          end
        end
      end

      S_READ: begin
        mem_re = 1'b1;
        if (multi && (pos_q != '0)) begin
          mem_raddr = AW'(pos_q - CW'(1));
        end
        state_d = S_EMIT;
      end

      S_EMIT: begin
        out_din.row_valid      = 1'b1;
        out_din.key            = gkey_q;
        out_din.version        = mem_rdata.version;
        out_din.payload        = mem_rdata.payload;
        out_din.compacted_flag = 1'b1;
        out_din.status         = STAT_OK;
        out_din.first_flag     = (pos_q == '0);
        out_din.shadow_flag    = multi && (pos_q == '0);
        out_din.seq            = (multi && (pos_q == '0)) ? SHADOW_SEQ : '0;
        out_din.last_flag      = last_pos;
        out_din.last_result    = last_pos;
        if (out_free) begin
          out_load = 1'b1;
          if (last_pos) begin
            count_d = '0;
            state_d = S_IDLE;
            if (pend_q) begin
              mem_we     = 1'b1;
              mem_wdata  = pent_q;
              gkey_d     = pkey_q;
              tail_seq_d = pseq_q;
              tail_ver_d = pent_q.version;
              count_d    = CW'(1);
              pend_d     = 1'b0;
            end
          end else begin
            pos_d   = pos_q + CW'(1);
            state_d = S_READ;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      pos_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pos_q   <= pos_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gkey_q     <= gkey_d;
    tail_seq_q <= tail_seq_d;
    tail_ver_q <= tail_ver_d;
    pkey_q     <= pkey_d;
    pseq_q     <= pseq_d;
    pent_q     <= pent_d;
  end

  assign row_valid_o      = out_dout.row_valid;
  assign out_key_o        = out_dout.key;
  assign out_version_o    = out_dout.version;
  assign out_seq_o        = out_dout.seq;
  assign out_payload_o    = out_dout.payload;
  assign first_flag_o     = out_dout.first_flag;
  assign last_flag_o      = out_dout.last_flag;
  assign shadow_flag_o    = out_dout.shadow_flag;
  assign compacted_flag_o = out_dout.compacted_flag;
  assign status_o         = out_dout.status;
  assign last_result_o    = out_dout.last_result;

endmodule

>>> dv/tb_multi_version_row_compactor.sv
// ---------------------------------------------------------------------------
// tb_multi_version_row_compactor
// Self-checking bench: drives sorted and unsorted row pushes and finish requests,
// predicts every group flush and status result, and compares each result
// field by field under random idling on both sides.
// ---------------------------------------------------------------------------
module tb_multi_version_row_compactor;
  import mvrc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QDEPTH      = QUEUE_DEPTH_DEF;
  localparam int          HOLD_CYCLES = 300;
  localparam int          STALL_LIMIT = 4000;

  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [VER_W-1:0] ver;
    logic [SEQ_W-1:0] seq;
    logic [PAY_W-1:0] pay;
  } row_req_t;

  logic                     clk_i            = 1'b0;
  logic                     rst_ni           = 1'b0;
  logic                     in_valid_i       = 1'b0;
  logic                     in_ready_o;
  logic                     operation_i      = 1'b0;
  logic [KEY_W-1:0]         row_key_i        = '0;
  logic [VER_W-1:0]         trans_version_i  = '0;
  logic [SEQ_W-1:0]         seq_number_i     = '0;
  logic [PAY_W-1:0]         payload_handle_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i      = 1'b0;
  logic                     row_valid_o;
  logic [KEY_W-1:0]         out_key_o;
  logic [VER_W-1:0]         out_version_o;
  logic signed [OSEQ_W-1:0] out_seq_o;
  logic [PAY_W-1:0]         out_payload_o;
  logic                     first_flag_o;
  logic                     last_flag_o;
  logic                     shadow_flag_o;
  logic                     compacted_flag_o;
  logic [2:0]               status_o;
  logic                     last_result_o;

  multi_version_row_compactor #(
    .QUEUE_DEPTH(QDEPTH)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .row_key_i       (row_key_i),
    .trans_version_i (trans_version_i),
    .seq_number_i    (seq_number_i),
    .payload_handle_i(payload_handle_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .row_valid_o     (row_valid_o),
    .out_key_o       (out_key_o),
    .out_version_o   (out_version_o),
    .out_seq_o       (out_seq_o),
    .out_payload_o   (out_payload_o),
    .first_flag_o    (first_flag_o),
    .last_flag_o     (last_flag_o),
    .shadow_flag_o   (shadow_flag_o),
    .compacted_flag_o(compacted_flag_o),
    .status_o        (status_o),
    .last_result_o   (last_result_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Stimulus and expectation stores
  row_req_t row_requests[$];
  result_t  predicted_rows[$];
  row_req_t bus_req;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_asked    = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int mismatches    = 0;

  // Coverage tallies
  int push_cnt     = 0;
  int finish_cnt   = 0;
  int rows_out     = 0;
  int shadow_cnt   = 0;
  int biggest_grp  = 0;
  int stat_hits[5] = '{default: 0};

  logic [KEY_W-1:0] gen_key = '0;

  // Predictor state: the group of the current key
  logic [KEY_W-1:0] grp_key      = '0;
  logic [SEQ_W-1:0] grp_tail_seq = '0;
  int               grp_count    = 0;
  logic [VER_W-1:0] grp_ver[QDEPTH];
  logic [PAY_W-1:0] grp_pay[QDEPTH];

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Mostly small values so versions and sequences have room to rise
  function automatic logic [62:0] rand63();
    logic [63:0] w;
    w = rand64();
    return w[62:0] >> (($urandom_range(3) == 0) ? 0 : $urandom_range(62));
  endfunction

  task automatic push_status(input status_e st);
    result_t res;
    res             = '0;
    res.status      = st;
    res.last_result = 1'b1;
    predicted_rows.push_back(res);
    stat_hits[st]++;
  endtask

  task automatic emit_row(input int idx, input logic shadow, input logic last);
    result_t res;
    res                = '0;
    res.row_valid      = 1'b1;
    res.key            = grp_key;
    res.version        = grp_ver[idx];
    res.seq            = shadow ? SHADOW_SEQ : '0;
    res.payload        = grp_pay[idx];
    res.first_flag     = shadow || grp_count == 1;
    res.last_flag      = last;
    res.shadow_flag    = shadow;
    res.compacted_flag = 1'b1;
    res.status         = STAT_OK;
    res.last_result    = last;
    predicted_rows.push_back(res);
    rows_out++;
  endtask

  task automatic flush_group();
    if (grp_count > biggest_grp) biggest_grp = grp_count;
    if (grp_count == 1) begin
      emit_row(0, 1'b0, 1'b1);
    end else begin
      emit_row(0, 1'b1, 1'b0);
      shadow_cnt++;
      for (int i = 0; i < grp_count; i++) emit_row(i, 1'b0, i == grp_count - 1);
    end
    grp_count = 0;
  endtask

  task automatic start_group(input row_req_t r);
    grp_key      = r.key;
    grp_tail_seq = r.seq;
    grp_ver[0]   = r.ver;
    grp_pay[0]   = r.pay;
    grp_count    = 1;
  endtask

  task automatic predict_compaction(input row_req_t r);
    if (r.op == OP_FINISH) begin
      finish_cnt++;
      if (grp_count == 0) push_status(STAT_EMPTY);
      else flush_group();
    end else begin
      push_cnt++;
      if (grp_count == 0) begin
        start_group(r);
        push_status(STAT_OK);
      end else if (r.key < grp_key) begin
        push_status(STAT_KEY);
      end else if (r.key == grp_key) begin
        if (grp_ver[grp_count-1] > r.ver) begin
          push_status(STAT_VERSION);
        end else if (grp_ver[grp_count-1] == r.ver) begin
          // repeated version: first row wins, sequence must still rise
          push_status((grp_tail_seq >= r.seq) ? STAT_VERSION : STAT_OK);
        end else if (grp_count >= QDEPTH) begin
          push_status(STAT_FULL);
        end else begin
          grp_ver[grp_count] = r.ver;
          grp_pay[grp_count] = r.pay;
          grp_tail_seq       = r.seq;
          grp_count++;
          push_status(STAT_OK);
        end
      end else begin
        // larger key: emit the old group, no status result of its own
        flush_group();
        start_group(r);
      end
    end
  endtask

  task automatic add_request(input logic op, input logic [KEY_W-1:0] key,
                             input logic [VER_W-1:0] ver, input logic [SEQ_W-1:0] seq,
                             input logic [PAY_W-1:0] pay);
    row_req_t r;
    r.op  = op;
    r.key = key;
    r.ver = ver;
    r.seq = seq;
    r.pay = pay;
    row_requests.push_back(r);
  endtask

  task automatic load_directed();
    logic [KEY_W-1:0] k;
    k = 64'h0123_4567_89ab_cdef;
    add_request(OP_FINISH, '0, '0, '0, '0);          // finish on empty queue
    add_request(OP_PUSH, '1, '1, '1, '1);            // all fields at maximum
    add_request(OP_FINISH, '1, '1, '1, '1);          // single-row group
    add_request(OP_PUSH, '0, '0, '0, '0);            // smaller key into empty queue
    add_request(OP_FINISH, '0, '0, '0, '0);
    add_request(OP_PUSH, k, 63'd10, 63'd5, 32'hdead_beef);
    add_request(OP_PUSH, k, 63'd10, 63'd5, 32'h1111_1111);   // same seq
    add_request(OP_PUSH, k, 63'd10, 63'd6, 32'h2222_2222);   // same version, rising seq
    add_request(OP_PUSH, k, 63'd9, 63'd7, 32'h3333_3333);    // version falls
    add_request(OP_PUSH, k - 1, 63'd20, 63'd8, 32'h4444_4444); // key falls
    add_request(OP_PUSH, k, 63'd11, 63'd7, 32'h5555_5555);
    add_request(OP_PUSH, k + 1, 63'd3, 63'd1, 32'h6666_6666); // flushes two-row group
    for (int i = 4; i <= 19; i++)                      // fills queue, last one overflows
      add_request(OP_PUSH, k + 1, 63'(i), 63'(i), $urandom());
    add_request(OP_FINISH, '0, '0, '0, '0);            // full group out
  endtask

  // Mostly well-formed ascending groups, with some broken requests mixed in
  task automatic gen_random(input int n);
    int               made;
    int               gsize;
    logic [KEY_W-1:0] k;
    logic [VER_W-1:0] v;
    logic [SEQ_W-1:0] s;
    made = 0;
    while (made < n) begin
      if ($urandom_range(3) == 0) begin
        add_request(OP_FINISH, rand64(), rand63(), rand63(), $urandom());
        made++;
        if ($urandom_range(3) == 0) begin
          add_request(OP_FINISH, rand64(), rand63(), rand63(), $urandom());
          made++;
        end
        k = rand64();
      end else begin
        k = gen_key + 64'd1 + $urandom_range(1000);
      end
      gen_key = k;
      gsize   = ($urandom_range(7) == 0) ? QDEPTH + 1 : $urandom_range(5, 1);
      v       = rand63();
      s       = rand63();
      for (int i = 0; i < gsize; i++) begin
        add_request(OP_PUSH, k, v, s, $urandom());
        made++;
        case ($urandom_range(11))
          0: if (k != 0) begin
            add_request(OP_PUSH, k - 1, v + 1, s + 1, $urandom());
            made++;
          end
          1: if (v != 0) begin
            add_request(OP_PUSH, k, v - 1, s + 1, $urandom());
            made++;
          end
          2: begin
            add_request(OP_PUSH, k, v, s, $urandom());
            made++;
          end
          3: begin
            s = s + 1 + $urandom_range(7);
            add_request(OP_PUSH, k, v, s, $urandom());
            made++;
          end
          default: ;
        endcase
        v = v + 1 + $urandom_range(3);
        s = s + 1 + $urandom_range(3);
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (row_requests.size() != 0 || in_valid_i || predicted_rows.size() != 0);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Request driver
  always @(posedge clk_i) begin : drive_requests
    logic next_valid;
    if (rst_ni) begin
      next_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        predict_compaction(bus_req);
        next_valid = 1'b0;
      end
      if (!next_valid && row_requests.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        bus_req          = row_requests.pop_front();
        next_valid       = 1'b1;
        operation_i      <= bus_req.op;
        row_key_i        <= bus_req.key;
        trans_version_i  <= bus_req.ver;
        seq_number_i     <= bus_req.seq;
        payload_handle_i <= bus_req.pay;
      end
      in_valid_i <= next_valid;
    end
  end

  // Result-side ready, with an occasional long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_asked != hold_served) begin
      out_ready_i <= 1'b0;
      hold_served <= hold_served + 1;
      hold_left   <= HOLD_CYCLES;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin : watch_results
    result_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (predicted_rows.size() == 0) begin
        $error("result with no request pending: key %0h status %0d", out_key_o, status_o);
        mismatches++;
      end else begin
        exp_r = predicted_rows.pop_front();
        check_field("row_valid", exp_r.row_valid, row_valid_o);
        check_field("out_key", exp_r.key, out_key_o);
        check_field("out_version", exp_r.version, out_version_o);
        check_field("out_seq", exp_r.seq, out_seq_o);
        check_field("out_payload", exp_r.payload, out_payload_o);
        check_field("first_flag", exp_r.first_flag, first_flag_o);
        check_field("last_flag", exp_r.last_flag, last_flag_o);
        check_field("shadow_flag", exp_r.shadow_flag, shadow_flag_o);
        check_field("compacted_flag", exp_r.compacted_flag, compacted_flag_o);
        check_field("status", exp_r.status, status_o);
        check_field("last_result", exp_r.last_result, last_result_o);
      end
    end
  end

  // Watchdog: no handshake on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("stalled for %0d cycles with %0d results outstanding",
               quiet_cycles, predicted_rows.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    send_idle_pct = 33;
    recv_idle_pct = 47;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    load_directed();
    gen_random(70);
    wait_drained();

    send_idle_pct = 47;
    recv_idle_pct = 33;
    gen_random(70);
    wait_drained();

    // no idling, but one long result-side stall to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    gen_random(60);
    hold_asked++;
    wait_drained();
    repeat (10) @(posedge clk_i);

    $display("Covered %0d pushes, %0d finishes; %0d rows out, %0d shadow groups, largest group %0d",
             push_cnt, finish_cnt, rows_out, shadow_cnt, biggest_grp);
    $display("Status results: ok %0d, key order %0d, version order %0d, empty %0d, full %0d",
             stat_hits[STAT_OK], stat_hits[STAT_KEY], stat_hits[STAT_VERSION],
             stat_hits[STAT_EMPTY], stat_hits[STAT_FULL]);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
sv/mvrc_pkg.sv
sv/mvrc_queue_mem.sv
sv/mvrc_out_reg.sv
sv/multi_version_row_compactor.sv
dv/tb_multi_version_row_compactor.sv
